>>> hw/rtl/ethiopian_gregorian_date_converter_defines.svh
// Assertion macros for the date converter RTL.
`ifndef ETHIOPIAN_GREGORIAN_DATE_CONVERTER_DEFINES_SVH
`define ETHIOPIAN_GREGORIAN_DATE_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define EGDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EGDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/egdc_pkg.sv
// Shared types, constants and calendar tables for the date converter.
package egdc_pkg;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned JDN_W     = 23;
  localparam int unsigned FRONT_STG = 2;
  localparam int unsigned BACK_STG  = 5;
  localparam int unsigned NSTG      = FRONT_STG + BACK_STG;

  // conversion direction
  localparam logic KIND_G2E = 1'b0;
  localparam logic KIND_E2G = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_MONTH = 2'd1,
    ERR_DAY   = 2'd2,
    ERR_EPOCH = 2'd3
  } err_e;

  localparam logic [JDN_W-1:0] ETH_EPOCH_JDN = 23'd1724221;

  // floor(2^32 / 1461), floor(2^32 / 146097), ceil-ish 2^19 / 100 (exact below 43690)
  localparam logic [21:0] RECIP_1461   = 22'd2939744;
  localparam logic [14:0] RECIP_146097 = 15'd29398;
  localparam logic [12:0] RECIP_100    = 13'd5243;

  typedef struct packed {
    logic             kind;
    err_e             err;
    logic [JDN_W-1:0] jdn;
  } front_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [JDN_W-1:0]   jdn;
    err_e               err;
  } result_t;

  // Day offset of a March-based month: (153 * m + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] v;
    unique case (m)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      4'd12:   v = 9'd367;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // (5 * e + 2) / 153 for a day of the March-based year
  function automatic logic [3:0] greg_month_idx(input logic [8:0] e);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k < 12; k++) begin
      if (e >= month_start(4'(k))) n = n + 4'd1;
    end
    return n;
  endfunction

  // doy / 30 for a day of the Ethiopian year
  function automatic logic [3:0] eth_month_idx(input logic [8:0] doy);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= 12; k++) begin
      if (doy >= 9'(30 * k)) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/egdc_front.sv
// Front end: input date to day number and error code, two register stages.
module egdc_front (
  input  logic                            clk_i,
  input  logic [egdc_pkg::FRONT_STG-1:0]  en_i,
  input  logic                            kind_i,
  input  logic [egdc_pkg::YEAR_W-1:0]     year_i,
  input  logic [egdc_pkg::MONTH_W-1:0]    month_i,
  input  logic [egdc_pkg::DAY_W-1:0]      day_i,
  output egdc_pkg::front_t                res_o
);
  import egdc_pkg::*;

  // stage 1 combinational
  logic             early;
  logic [14:0]      gy_d;
  logic [3:0]       gm;
  logic [27:0]      p100;
  logic [22:0]      gy365_d;
  logic [7:0]       g100_d;
  logic [9:0]       gmd_d;
  logic [4:0]       lim;
  err_e             eerr_d;
  logic [22:0]      e365_d;
  logic [8:0]       emd_d;

  // stage 1 registers
  logic             s1_kind_q;
  logic [14:0]      s1_gy_q;
  logic [22:0]      s1_gy365_q;
  logic [7:0]       s1_g100_q;
  logic [9:0]       s1_gmd_q;
  err_e             s1_eerr_q;
  logic [22:0]      s1_e365_q;
  logic [11:0]      s1_eyq_q;
  logic [8:0]       s1_emd_q;

  // stage 2
  logic [23:0]      gjdn_full;
  logic [JDN_W-1:0] gjdn;
  logic [JDN_W-1:0] ejdn;
  front_t           res_d;
  front_t           s2_q;

  always_comb begin
    // January and February count as months of the previous March-based year
    early   = (month_i <= 4'd2);
    gy_d    = 15'(year_i) + 15'd4800 - 15'(early);
    gm      = early ? month_i + 4'd9 : month_i - 4'd3;
    gy365_d = 23'(24'(gy_d) * 24'd365);
    p100    = 28'(gy_d) * 28'(RECIP_100);
    g100_d  = p100[26:19];
    gmd_d   = 10'(month_start(gm)) + 10'(day_i);

    lim = (month_i == 4'd13) ? ((year_i[1:0] == 2'b11) ? 5'd6 : 5'd5) : 5'd30;
    priority if (month_i == 4'd0 || month_i > 4'd13) eerr_d = ERR_MONTH;
    else if (day_i == 5'd0 || day_i > lim)           eerr_d = ERR_DAY;
    else if (year_i == '0)                           eerr_d = ERR_EPOCH;
    else                                             eerr_d = ERR_OK;
    e365_d = 23'(year_i) * 23'd365;
    emd_d  = 9'(month_i) * 9'd30 + 9'(day_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_kind_q  <= kind_i;
      s1_gy_q    <= gy_d;
      s1_gy365_q <= gy365_d;
      s1_g100_q  <= g100_d;
      s1_gmd_q   <= gmd_d;
      s1_eerr_q  <= eerr_d;
      s1_e365_q  <= e365_d;
      s1_eyq_q   <= year_i[YEAR_W-1:2];
      s1_emd_q   <= emd_d;
    end
  end

  always_comb begin
    gjdn_full = 24'(s1_gmd_q) + 24'(s1_gy365_q) + 24'(s1_gy_q >> 2) - 24'(s1_g100_q)
              + 24'(s1_g100_q >> 2) - 24'd32045;
    gjdn      = gjdn_full[JDN_W-1:0];
    // epoch minus one day, one year and one month folded into one constant
    ejdn      = 23'd1723825 + s1_e365_q + 23'(s1_eyq_q) + 23'(s1_emd_q);

    res_d.kind = s1_kind_q;
    if (s1_kind_q == KIND_E2G) begin
      res_d.err = s1_eerr_q;
      res_d.jdn = (s1_eerr_q == ERR_MONTH || s1_eerr_q == ERR_DAY) ? '0 : ejdn;
    end else begin
      res_d.err = (gjdn < ETH_EPOCH_JDN) ? ERR_EPOCH : ERR_OK;
      res_d.jdn = gjdn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) s2_q <= res_d;
  end

  assign res_o = s2_q;

endmodule

>>> hw/rtl/egdc_back.sv
// Back end: day number to Ethiopian and Gregorian dates, five register stages.
module egdc_back (
  input  logic                           clk_i,
  input  logic [egdc_pkg::BACK_STG-1:0]  en_i,
  input  egdc_pkg::front_t               front_i,
  output egdc_pkg::result_t              res_o
);
  import egdc_pkg::*;

  // stage 3
  logic [JDN_W-1:0] since_d;
  logic [24:0]      xe_d;
  logic [46:0]      pe;
  logic [JDN_W-1:0] ag;
  logic [24:0]      xg_d;
  logic [39:0]      pg;
  logic             s3_kind_q;
  err_e             s3_err_q;
  logic [JDN_W-1:0] s3_jdn_q;
  logic [JDN_W-1:0] s3_since_q;
  logic [24:0]      s3_xe_q;
  logic [14:0]      s3_qe_q;
  logic [24:0]      s3_xg_q;
  logic [7:0]       s3_qb_q;

  // stage 4
  logic [24:0]      re;
  logic [14:0]      ey_d;
  logic [24:0]      rg;
  logic [24:0]      rg_fix;
  logic [7:0]       b_d;
  logic             s4_kind_q;
  err_e             s4_err_q;
  logic [JDN_W-1:0] s4_jdn_q;
  logic [JDN_W-1:0] s4_since_q;
  logic [14:0]      s4_ey_q;
  logic [7:0]       s4_b_q;
  logic [15:0]      s4_c_q;

  // stage 5
  logic [23:0]      doy_full;
  logic [17:0]      x2_d;
  logic [39:0]      p2;
  logic             s5_kind_q;
  err_e             s5_err_q;
  logic [JDN_W-1:0] s5_jdn_q;
  logic [14:0]      s5_ey_q;
  logic [8:0]       s5_doy_q;
  logic [7:0]       s5_b_q;
  logic [17:0]      s5_x2_q;
  logic [6:0]       s5_qd_q;

  // stage 6
  logic [3:0]       mq;
  logic [3:0]       emon_d;
  logic [4:0]       eday_d;
  logic [17:0]      r2;
  logic [17:0]      r2_fix;
  logic [6:0]       d_d;
  logic             s6_kind_q;
  err_e             s6_err_q;
  logic [JDN_W-1:0] s6_jdn_q;
  logic [14:0]      s6_ey_q;
  logic [3:0]       s6_emon_q;
  logic [4:0]       s6_eday_q;
  logic [7:0]       s6_b_q;
  logic [6:0]       s6_d_q;
  logic [8:0]       s6_e_q;

  // stage 7
  logic [3:0]       gm;
  logic             wrap;
  logic [3:0]       gmon;
  logic [4:0]       gday;
  logic [15:0]      gyear_full;
  result_t          res_d;
  result_t          s7_q;

  // ---- stage 3: reciprocal multiplies for year-of-cycle and century ----
  always_comb begin
    since_d = front_i.jdn - ETH_EPOCH_JDN;
    xe_d    = {since_d, 2'b00} + 25'd1463;
    pe      = 47'(xe_d) * 47'(RECIP_1461);
    ag      = front_i.jdn + 23'd32044;
    xg_d    = {ag, 2'b11};
    pg      = 40'(xg_d) * 40'(RECIP_146097);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s3_kind_q  <= front_i.kind;
      s3_err_q   <= front_i.err;
      s3_jdn_q   <= front_i.jdn;
      s3_since_q <= since_d;
      s3_xe_q    <= xe_d;
      s3_qe_q    <= pe[46:32];
      s3_xg_q    <= xg_d;
      s3_qb_q    <= pg[39:32];
    end
  end

  // ---- stage 4: quotient estimates are low by at most one ----
  always_comb begin
    re   = s3_xe_q - 25'(26'(s3_qe_q) * 26'd1461);
    ey_d = (re >= 25'd1461) ? s3_qe_q + 15'd1 : s3_qe_q;
    rg   = s3_xg_q - 25'(26'(s3_qb_q) * 26'd146097);
    if (rg >= 25'd146097) begin
      b_d    = s3_qb_q + 8'd1;
      rg_fix = rg - 25'd146097;
    end else begin
      b_d    = s3_qb_q;
      rg_fix = rg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s4_kind_q  <= s3_kind_q;
      s4_err_q   <= s3_err_q;
      s4_jdn_q   <= s3_jdn_q;
      s4_since_q <= s3_since_q;
      s4_ey_q    <= ey_d;
      s4_b_q     <= b_d;
      s4_c_q     <= rg_fix[17:2];
    end
  end

  // ---- stage 5: Ethiopian day of year, Gregorian year-in-century estimate ----
  always_comb begin
    doy_full = 24'(s4_since_q) + 24'd365 - 24'(s4_ey_q) * 24'd365 - 24'(s4_ey_q >> 2);
    x2_d     = {s4_c_q, 2'b11};
    p2       = 40'(x2_d) * 40'(RECIP_1461);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s5_kind_q <= s4_kind_q;
      s5_err_q  <= s4_err_q;
      s5_jdn_q  <= s4_jdn_q;
      s5_ey_q   <= s4_ey_q;
      s5_doy_q  <= doy_full[8:0];
      s5_b_q    <= s4_b_q;
      s5_x2_q   <= x2_d;
      s5_qd_q   <= p2[38:32];
    end
  end

  // ---- stage 6: Ethiopian month/day, Gregorian day of March-based year ----
  always_comb begin
    mq     = eth_month_idx(s5_doy_q);
    emon_d = mq + 4'd1;
    eday_d = 5'(s5_doy_q - 9'(mq) * 9'd30 + 9'd1);
    r2     = s5_x2_q - 18'(18'(s5_qd_q) * 18'd1461);
    if (r2 >= 18'd1461) begin
      d_d    = s5_qd_q + 7'd1;
      r2_fix = r2 - 18'd1461;
    end else begin
      d_d    = s5_qd_q;
      r2_fix = r2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s6_kind_q <= s5_kind_q;
      s6_err_q  <= s5_err_q;
      s6_jdn_q  <= s5_jdn_q;
      s6_ey_q   <= s5_ey_q;
      s6_emon_q <= emon_d;
      s6_eday_q <= eday_d;
      s6_b_q    <= s5_b_q;
      s6_d_q    <= d_d;
      s6_e_q    <= r2_fix[10:2];
    end
  end

  // ---- stage 7: Gregorian month/day/year and result select ----
  always_comb begin
    gm         = greg_month_idx(s6_e_q);
    wrap       = (gm >= 4'd10);
    gmon       = wrap ? gm - 4'd9 : gm + 4'd3;
    gday       = 5'(s6_e_q - month_start(gm) + 9'd1);
    gyear_full = 16'(s6_b_q) * 16'd100 + 16'(s6_d_q) + 16'(wrap) - 16'd4800;

    res_d.jdn = s6_jdn_q;
    res_d.err = s6_err_q;
    if (s6_err_q != ERR_OK) begin
      res_d.year  = '0;
      res_d.month = '0;
      res_d.day   = '0;
    end else if (s6_kind_q == KIND_E2G) begin
      res_d.year  = gyear_full[YEAR_W-1:0];
      res_d.month = gmon;
      res_d.day   = gday;
    end else begin
      res_d.year  = s6_ey_q[YEAR_W-1:0];
      res_d.month = s6_emon_q;
      res_d.day   = s6_eday_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) s7_q <= res_d;
  end

  assign res_o = s7_q;

endmodule

>>> hw/rtl/ethiopian_gregorian_date_converter.sv
// Top level of the Ethiopian / Gregorian date converter.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------------
//   in      | in_valid_i, in_ready_o | kind_i, in_year_i, in_month_i, in_day_i
//   out     | out_valid_o, out_ready_i | out_year_o, out_month_o, out_day_o,
//           |                        | julian_day_o, error_code_o
//
// One date per cycle sustained while out_ready_i is high; out_valid_o rises when a date reaches stage 7.
// Stages 1-2 form the day number and the input checks; stages 3-7 turn it back into
// dates by reciprocal multiplies for 1461 and 146097, each corrected a stage later.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled output only holds stages that are full: bubbles ahead of it still fill.
`include "ethiopian_gregorian_date_converter_defines.svh"

module ethiopian_gregorian_date_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [egdc_pkg::YEAR_W-1:0]    in_year_i,
  input  logic [egdc_pkg::MONTH_W-1:0]   in_month_i,
  input  logic [egdc_pkg::DAY_W-1:0]     in_day_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [egdc_pkg::YEAR_W-1:0]    out_year_o,
  output logic [egdc_pkg::MONTH_W-1:0]   out_month_o,
  output logic [egdc_pkg::DAY_W-1:0]     out_day_o,
  output logic [egdc_pkg::JDN_W-1:0]     julian_day_o,
  output logic [1:0]                     error_code_o
);
  import egdc_pkg::*;

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] valid_d;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vin;
  logic [NSTG-1:0] en;
  front_t          front;
  result_t         res;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin     = {valid_q[NSTG-2:0], in_valid_i};
    en      = vin & rdy[NSTG-1:0];
    valid_d = (rdy[NSTG-1:0] & vin) | (~rdy[NSTG-1:0] & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  egdc_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[FRONT_STG-1:0]),
    .kind_i  (kind_i),
    .year_i  (in_year_i),
    .month_i (in_month_i),
    .day_i   (in_day_i),
    .res_o   (front)
  );

  egdc_back u_back (
    .clk_i   (clk_i),
    .en_i    (en[NSTG-1:FRONT_STG]),
    .front_i (front),
    .res_o   (res)
  );

  assign in_ready_o   = rdy[0];
  assign out_valid_o  = valid_q[NSTG-1];
  assign out_year_o   = res.year;
  assign out_month_o  = res.month;
  assign out_day_o    = res.day;
  assign julian_day_o = res.jdn;
  assign error_code_o = res.err;

  `EGDC_ASSERT_NEXT(a_in_lands_stage1, clk_i, rst_ni, in_valid_i && in_ready_o, valid_q[0], "input transfer did not fill stage 1")

  `EGDC_ASSERT_IMPLY(a_ok_date_range, clk_i, rst_ni, out_valid_o && error_code_o == ERR_OK, out_month_o != 4'd0 && out_month_o <= 4'd13 && out_day_o != 5'd0 && julian_day_o >= ETH_EPOCH_JDN, "valid result with a malformed date")

  `EGDC_ASSERT_IMPLY(a_bad_input_zero, clk_i, rst_ni, out_valid_o && (error_code_o == ERR_MONTH || error_code_o == ERR_DAY), julian_day_o == '0 && out_year_o == '0 && out_month_o == '0 && out_day_o == '0, "rejected date carries nonzero fields")

  `EGDC_ASSERT_IMPLY(a_epoch_before, clk_i, rst_ni, out_valid_o && error_code_o == ERR_EPOCH, julian_day_o < ETH_EPOCH_JDN && out_year_o == '0 && out_month_o == '0, "pre-epoch flag on a day at or after the epoch")

endmodule

>>> test/tb_ethiopian_gregorian_date_converter.sv
// Testbench for the Ethiopian / Gregorian date converter: directed and random dates, scoreboarded.
module tb_ethiopian_gregorian_date_converter;
  import egdc_pkg::*;

  localparam int     WdLimit  = 2000;
  localparam int     HoldLen  = 150;
  localparam longint EpochJdn = ETH_EPOCH_JDN;

  typedef struct {
    logic               kind;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    bit                 pause;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [JDN_W-1:0]   jdn;
    err_e               err;
  } conv_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               kind_i      = KIND_G2E;
  logic [YEAR_W-1:0]  in_year_i   = '0;
  logic [MONTH_W-1:0] in_month_i  = '0;
  logic [DAY_W-1:0]   in_day_i    = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [YEAR_W-1:0]  out_year_o;
  logic [MONTH_W-1:0] out_month_o;
  logic [DAY_W-1:0]   out_day_o;
  logic [JDN_W-1:0]   julian_day_o;
  logic [1:0]         error_code_o;

  date_req_t date_q[$];
  conv_t     conv_q[$];
  conv_t     want_c;
  int        n_total   = 0;
  int        n_acc     = 0;
  int        n_done    = 0;
  int        n_err     = 0;
  int        idle_cnt  = 0;
  int        hold_left = 0;
  bit        held      = 1'b0;

  ethiopian_gregorian_date_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .in_year_i    (in_year_i),
    .in_month_i   (in_month_i),
    .in_day_i     (in_day_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_year_o   (out_year_o),
    .out_month_o  (out_month_o),
    .out_day_o    (out_day_o),
    .julian_day_o (julian_day_o),
    .error_code_o (error_code_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint eth_day_number(input longint y, input longint m, input longint d);
    return EpochJdn - 1 + 365 * (y - 1) + y / 4 + 30 * (m - 1) + d;
  endfunction

  function automatic conv_t convert_date(input logic k, input logic [YEAR_W-1:0] yr,
                                         input logic [MONTH_W-1:0] mo,
                                         input logic [DAY_W-1:0] dy);
    conv_t  r;
    longint y, m, d, a, yy, mm, jdn, ey, doy, em, lim, b, c, dd, e, gm;
    y = yr;
    m = mo;
    d = dy;
    r = '0;
    r.err = ERR_OK;
    if (k == KIND_G2E) begin
      // months 0..2 fall in the shifted Jan/Feb case, out-of-range days just roll over
      a = (m <= 2) ? 1 : 0;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      jdn = d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
      r.jdn = JDN_W'(jdn);
      if (jdn < EpochJdn) begin
        r.err = ERR_EPOCH;
      end else begin
        ey = (4 * (jdn - EpochJdn) + 1463) / 1461;
        doy = jdn - eth_day_number(ey, 1, 1);
        em = doy / 30 + 1;
        r.year = YEAR_W'(ey);
        r.month = MONTH_W'(em);
        r.day = DAY_W'(doy - 30 * (em - 1) + 1);
      end
    end else if (m < 1 || m > 13) begin
      r.err = ERR_MONTH;
    end else begin
      // Pagume has a sixth day when year mod 4 is 3
      lim = (m == 13) ? (((y % 4) == 3) ? 6 : 5) : 30;
      if (d < 1 || d > lim) begin
        r.err = ERR_DAY;
      end else begin
        jdn = eth_day_number(y, m, d);
        r.jdn = JDN_W'(jdn);
        if (y == 0) begin
          r.err = ERR_EPOCH;
        end else begin
          a = jdn + 32044;
          b = (4 * a + 3) / 146097;
          c = a - (146097 * b) / 4;
          dd = (4 * c + 3) / 1461;
          e = c - (1461 * dd) / 4;
          gm = (5 * e + 2) / 153;
          r.day = DAY_W'(e - (153 * gm + 2) / 5 + 1);
          r.month = MONTH_W'(gm + 3 - 12 * (gm / 10));
          r.year = YEAR_W'(100 * b + dd - 4800 + gm / 10);
        end
      end
    end
    return r;
  endfunction

  function automatic int idle_pct(input bit rx, input int n);
    if (n < n_total / 3) return rx ? 47 : 37;
    if (n < 2 * n_total / 3) return rx ? 37 : 47;
    return 0;
  endfunction

  task automatic add_date(input logic k, input int y, input int m, input int d,
                          input bit pause = 1'b0);
    date_req_t q;
    q.kind = k;
    q.year = YEAR_W'(y);
    q.month = MONTH_W'(m);
    q.day = DAY_W'(d);
    q.pause = pause;
    date_q.push_back(q);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_err++;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        conv_q.push_back(convert_date(kind_i, in_year_i, in_month_i, in_day_i));
        n_acc <= n_acc + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        // a pause item waits until everything in flight has come out
        if (date_q.size() != 0 &&
            !(date_q[0].pause && (in_valid_i || n_acc != n_done)) &&
            $urandom_range(99) >= idle_pct(1'b0, n_acc)) begin
          in_valid_i <= 1'b1;
          kind_i <= date_q[0].kind;
          in_year_i <= date_q[0].year;
          in_month_i <= date_q[0].month;
          in_day_i <= date_q[0].day;
          void'(date_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (conv_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d-%0d-%0d jdn %0d err %0d",
                   $time, out_year_o, out_month_o, out_day_o, julian_day_o, error_code_o);
          n_err++;
        end else begin
          want_c = conv_q.pop_front();
          check_field("out_year", want_c.year, out_year_o);
          check_field("out_month", want_c.month, out_month_o);
          check_field("out_day", want_c.day, out_day_o);
          check_field("julian_day", want_c.jdn, julian_day_o);
          check_field("error_code", want_c.err, error_code_o);
        end
        n_done <= n_done + 1;
      end
      // one long hold-off while the sender keeps pushing, so the pipe backs up
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && n_acc >= 2 * n_total / 3 + 50) begin
        held = 1'b1;
        hold_left = HoldLen;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1, n_acc));
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt == WdLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int k, y, m, d, lim, sel;
    // Gregorian side: epoch boundary, range ends, unchecked month and day values
    add_date(KIND_G2E, 1, 1, 1);
    add_date(KIND_G2E, 8, 8, 26);
    add_date(KIND_G2E, 8, 8, 27);
    add_date(KIND_G2E, 9999, 12, 31);
    add_date(KIND_G2E, 2000, 0, 0);
    add_date(KIND_G2E, 2001, 15, 31);
    add_date(KIND_G2E, 2024, 2, 29);
    add_date(KIND_G2E, 0, 6, 15);
    add_date(KIND_G2E, 16383, 15, 31);
    // Ethiopian side: bad month, bad day, Pagume length, year zero, wrap
    add_date(KIND_E2G, 2015, 0, 0);
    add_date(KIND_E2G, 2015, 14, 10);
    add_date(KIND_E2G, 2015, 15, 31);
    add_date(KIND_E2G, 2015, 1, 0);
    add_date(KIND_E2G, 2015, 1, 31);
    add_date(KIND_E2G, 2, 13, 5);
    add_date(KIND_E2G, 2, 13, 6);
    add_date(KIND_E2G, 3, 13, 6);
    add_date(KIND_E2G, 3, 13, 7);
    add_date(KIND_E2G, 0, 1, 1);
    add_date(KIND_E2G, 1, 1, 1);
    add_date(KIND_E2G, 9999, 12, 30);
    add_date(KIND_E2G, 9999, 13, 5);
    add_date(KIND_E2G, 16383, 13, 6);
    for (int n = 0; n < 1000; n++) begin
      k = $urandom_range(1);
      sel = $urandom_range(99);
      if (sel < 4) y = $urandom_range(16383);
      else if (sel < 10) y = $urandom_range(1, 40);
      else if (sel < 14) y = $urandom_range(9960, 9999);
      else y = $urandom_range(1, 9999);
      if (k == KIND_E2G) begin
        if ($urandom_range(99) < 80) begin
          m = $urandom_range(1, 13);
          lim = (m == 13) ? (((y % 4) == 3) ? 6 : 5) : 30;
          d = $urandom_range(1, lim);
        end else begin
          m = $urandom_range(15);
          d = $urandom_range(31);
        end
      end else if ($urandom_range(99) < 85) begin
        m = $urandom_range(1, 12);
        d = $urandom_range(1, 31);
      end else begin
        m = $urandom_range(15);
        d = $urandom_range(31);
      end
      add_date(k[0], y, m, d, n == 400);
    end
    n_total = date_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (n_acc != n_total || n_done != n_acc) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (conv_q.size() != 0) begin
      $display("%0t: %0d results missing", $time, conv_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> ethiopian_gregorian_date_converter.f
+incdir+hw/rtl
hw/rtl/egdc_pkg.sv
hw/rtl/egdc_front.sv
hw/rtl/egdc_back.sv
hw/rtl/ethiopian_gregorian_date_converter.sv
test/tb_ethiopian_gregorian_date_converter.sv
